/* sv/vector3_ops_unit_defines.svh */
// assertion macros shared by the vector3 ops unit
// expects signals named clock and reset in the module that uses them
`ifndef VECTOR3_OPS_UNIT_DEFINES_SVH
`define VECTOR3_OPS_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define V3O_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("vector3 ops unit check failed");

// next-cycle implication, held off during reset
`define V3O_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("vector3 ops unit check failed");

`endif

/* sv/v3o_pkg.sv */
// shared types for the vector3 ops unit
// operation codes and per-lane overflow flags; no dependencies
package v3o_pkg;

   typedef enum logic [3:0] {
      KIND_ADD    = 4'd0,
      KIND_SUB    = 4'd1,
      KIND_SCALE  = 4'd2,
      KIND_DOT    = 4'd3,
      KIND_CROSS  = 4'd4,
      KIND_LENGTH = 4'd5,
      KIND_NORM   = 4'd6,
      KIND_UCROSS = 4'd7,
      KIND_USUM   = 4'd8
   } kind_type;

   typedef struct packed {
      logic add_ovf;
      logic sub_ovf;
      logic scale_ovf;
      logic cross_ovf;
   } lane_flags_type;

endpackage

/* sv/v3o_if.sv */
// request and response channel interfaces of the vector3 ops unit
// valid/ready handshake with the payload fields; no dependencies
interface v3o_req_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic [3:0]          kind;
   logic signed [W-1:0] ax;
   logic signed [W-1:0] ay;
   logic signed [W-1:0] az;
   logic signed [W-1:0] bx;
   logic signed [W-1:0] by;
   logic signed [W-1:0] bz;
   logic signed [W-1:0] factor;
   modport source (output valid, kind, ax, ay, az, bx, by, bz, factor, input ready);
   modport sink (input valid, kind, ax, ay, az, bx, by, bz, factor, output ready);
endinterface

interface v3o_rsp_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] rx;
   logic signed [W-1:0] ry;
   logic signed [W-1:0] rz;
   logic signed [W-1:0] scalar_out;
   logic                zero_length;
   logic                overflow;
   modport source (output valid, rx, ry, rz, scalar_out, zero_length, overflow, input ready);
   modport sink (input valid, rx, ry, rz, scalar_out, zero_length, overflow, output ready);
endinterface

/* sv/v3o_lane.sv */
// one component lane: products, sums, scale and cross term, rounded and saturated
// depends on v3o_pkg for the flag struct
module v3o_lane #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [W-1:0]     a_i,
   input  logic signed [W-1:0]     b_i,
   input  logic signed [W-1:0]     a_j,
   input  logic signed [W-1:0]     b_k,
   input  logic signed [W-1:0]     a_k,
   input  logic signed [W-1:0]     b_j,
   input  logic signed [W-1:0]     factor,
   output logic signed [2*W-1:0]   dot_prod,
   output logic signed [W-1:0]     add_res,
   output logic signed [W-1:0]     sub_res,
   output logic signed [W-1:0]     scale_res,
   output logic signed [W-1:0]     cross_res,
   output v3o_pkg::lane_flags_type flags
);
   localparam int XW = 2*W + 2;
   localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] MINV = ~MAXV;
   localparam logic signed [XW-1:0] HALF = XW'(1) << (F-1);

   function automatic logic [W:0] sat_fn(input logic signed [XW-1:0] v);
      logic [W:0] r;
      if (v > MAXV) begin
         r = {1'b1, MAXV[W-1:0]};
      end else if (v < MINV) begin
         r = {1'b1, MINV[W-1:0]};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   function automatic logic signed [XW-1:0] round_fn(input logic signed [XW-1:0] v);
      return (v + HALF) >>> F;
   endfunction

   logic signed [2*W-1:0] pc1_in, pc2_in, pd_in, ps_in;
   logic signed [2*W-1:0] pc1_ff, pc2_ff, pd_ff, ps_ff;
   logic signed [W:0]     sum_in, dif_in, sum_ff, dif_ff;
   logic signed [XW-1:0]  crs_x;
   logic [W:0]            cr_s, sc_s, ad_s, sb_s;
   logic signed [W-1:0]   add_ff, sub_ff, scale_ff, cross_ff;
   v3o_pkg::lane_flags_type flags_ff;

   // product stage
   assign pc1_in = a_j * b_k;
   assign pc2_in = a_k * b_j;
   assign pd_in  = a_i * b_i;
   assign ps_in  = factor * a_i;
   assign sum_in = {a_i[W-1], a_i} + {b_i[W-1], b_i};
   assign dif_in = {a_i[W-1], a_i} - {b_i[W-1], b_i};

   always_ff @(posedge clock) begin
      if (en) begin
         pc1_ff <= pc1_in;
         pc2_ff <= pc2_in;
         pd_ff  <= pd_in;
         ps_ff  <= ps_in;
         sum_ff <= sum_in;
         dif_ff <= dif_in;
      end
   end

   // round and saturate stage
   assign crs_x = XW'(pc1_ff) - XW'(pc2_ff);
   assign cr_s  = sat_fn(round_fn(crs_x));
   assign sc_s  = sat_fn(round_fn(XW'(ps_ff)));
   assign ad_s  = sat_fn(XW'(sum_ff));
   assign sb_s  = sat_fn(XW'(dif_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         cross_ff           <= cr_s[W-1:0];
         scale_ff           <= sc_s[W-1:0];
         add_ff             <= ad_s[W-1:0];
         sub_ff             <= sb_s[W-1:0];
         flags_ff.cross_ovf <= cr_s[W];
         flags_ff.scale_ovf <= sc_s[W];
         flags_ff.add_ovf   <= ad_s[W];
         flags_ff.sub_ovf   <= sb_s[W];
      end
   end

   assign dot_prod  = pd_ff;
   assign add_res   = add_ff;
   assign sub_res   = sub_ff;
   assign scale_res = scale_ff;
   assign cross_res = cross_ff;
   assign flags     = flags_ff;
endmodule

/* sv/v3o_sqrt.sv */
// pipelined integer square root, one root bit per stage, rounded to nearest
// no package dependencies
module v3o_sqrt #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] sum_sq,
   output logic [W:0]     len
);
   logic [2*W-1:0] rem_ff  [W];
   logic [W-1:0]   root_ff [W];
   logic [W:0]     len_in, len_ff;

   for (genvar g = 0; g < W; g++) begin : g_bit
      localparam int B = W - 1 - g;
      logic [2*W-1:0] prem, trial, rem_in;
      logic [W-1:0]   proot, root_in;

      if (g == 0) begin : g_first
         assign prem  = sum_sq;
         assign proot = '0;
      end else begin : g_rest
         assign prem  = rem_ff[g-1];
         assign proot = root_ff[g-1];
      end

      // (r + 2^B)^2 - r^2, with r holding only bits above B
      assign trial = ((2*W)'(proot) << (B+1)) | ((2*W)'(1) << (2*B));

      always_comb begin
         if (prem >= trial) begin
            rem_in  = prem - trial;
            root_in = proot | (W'(1) << B);
         end else begin
            rem_in  = prem;
            root_in = proot;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
         end
      end
   end

   // round up when the remainder exceeds the root
   assign len_in = {1'b0, root_ff[W-1]} + (W+1)'(rem_ff[W-1] > (2*W)'(root_ff[W-1]));

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff <= len_in;
      end
   end

   assign len = len_ff;
endmodule

/* sv/v3o_div.sv */
// pipelined restoring divider for one normalized component, rounded to nearest
// quotient |c| * 2^F / len, bounded by 2^F + 1; no package dependencies
module v3o_div #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] mag,
   input  logic [W:0]   den,
   output logic [F+1:0] quo
);
   logic [W:0]   rem_ff [F+1];
   logic [F:0]   q_ff   [F+1];
   logic [W:0]   d_ff   [F+1];
   logic         up;
   logic [F+1:0] quo_in, quo_ff;

   for (genvar j = 0; j <= F; j++) begin : g_step
      logic [W:0]   prem, pd;
      logic [F:0]   pq;
      logic         pb, take;
      logic [W+1:0] trial, diff;
      logic [W:0]   rem_in;
      logic [F:0]   q_in;

      if (j == 0) begin : g_first
         // quotient stays below 2^(F+1), so the top numerator bits start as remainder
         assign prem = {2'b00, mag[W-1:1]};
         assign pq   = '0;
         assign pd   = den;
         assign pb   = mag[0];
      end else begin : g_rest
         assign prem = rem_ff[j-1];
         assign pq   = q_ff[j-1];
         assign pd   = d_ff[j-1];
         assign pb   = 1'b0;
      end

      assign trial  = {prem, pb};
      assign diff   = trial - {1'b0, pd};
      assign take   = trial >= {1'b0, pd};
      assign rem_in = take ? diff[W:0] : trial[W:0];
      assign q_in   = {pq[F-1:0], take};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
            d_ff[j]   <= pd;
         end
      end
   end

   assign up     = rem_ff[F] >= (d_ff[F] - rem_ff[F]);
   assign quo_in = {1'b0, q_ff[F]} + (F+2)'(up);

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;
endmodule

/* sv/vector3_ops_unit.sv */
// vector3 ops unit: add, sub, scale, dot, cross, length; normalize A, A x B or A + B
// throughput one request per cycle unless the output stalls; depth set by the sqrt
// pipeline (a root bit per stage) and the per-lane divider (a quotient bit per stage)
// synchronous reset clears only the stage valid bits; data registers are not reset
// depends on v3o_pkg, v3o_if, v3o_lane, v3o_sqrt, v3o_div
`include "vector3_ops_unit_defines.svh"

module vector3_ops_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   v3o_req_if.sink  req_ch,
   v3o_rsp_if.source rsp_ch
);
   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int XW  = 2*W + 2;
   // stage count: product, lane result, select, square, sum, sqrt, divide, output
   localparam int NST = W + F + 9;
   localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] MINV = ~MAXV;
   localparam logic signed [XW-1:0] HALF = XW'(1) << (F-1);

   // everything that rides along with a request through the deep stages
   typedef struct packed {
      v3o_pkg::kind_type   kind;
      logic [2:0][W-1:0]   rvec;
      logic [W-1:0]        scal;
      logic                ovf;
      logic [2:0]          neg;
      logic [2:0][W-1:0]   mag;
      logic [W:0]          len;
   } pay_type;

   function automatic logic [W:0] sat_fn(input logic signed [XW-1:0] v);
      logic [W:0] r;
      if (v > MAXV) begin
         r = {1'b1, MAXV[W-1:0]};
      end else if (v < MINV) begin
         r = {1'b1, MINV[W-1:0]};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   // whole pipeline moves together; the output register frees up when taken
   logic [NST-1:0] vld_ff;
   logic           adv;

   assign adv          = !vld_ff[NST-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_ch.valid};
      end
   end

   // ---------------- lanes: products and per-component results
   logic signed [W-1:0]     a_in [3];
   logic signed [W-1:0]     b_in [3];
   logic signed [2*W-1:0]   dprod [3];
   logic signed [W-1:0]     add_r [3];
   logic signed [W-1:0]     sub_r [3];
   logic signed [W-1:0]     scl_r [3];
   logic signed [W-1:0]     crs_r [3];
   v3o_pkg::lane_flags_type flg [3];

   assign a_in[0] = req_ch.ax;
   assign a_in[1] = req_ch.ay;
   assign a_in[2] = req_ch.az;
   assign b_in[0] = req_ch.bx;
   assign b_in[1] = req_ch.by;
   assign b_in[2] = req_ch.bz;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      v3o_lane #(.W(W), .F(F)) u_lane (
         .clock     (clock),
         .en        (adv),
         .a_i       (a_in[i]),
         .b_i       (b_in[i]),
         .a_j       (a_in[J]),
         .b_k       (b_in[K]),
         .a_k       (a_in[K]),
         .b_j       (b_in[J]),
         .factor    (req_ch.factor),
         .dot_prod  (dprod[i]),
         .add_res   (add_r[i]),
         .sub_res   (sub_r[i]),
         .scale_res (scl_r[i]),
         .cross_res (crs_r[i]),
         .flags     (flg[i])
      );
   end

   // kind and vector A follow the lanes for two stages
   v3o_pkg::kind_type        k1_ff, k2_ff;
   logic [2:0][W-1:0]        a1_ff, a2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_ff <= v3o_pkg::kind_type'(req_ch.kind);
         a1_ff <= {req_ch.az, req_ch.ay, req_ch.ax};
         k2_ff <= k1_ff;
         a2_ff <= a1_ff;
      end
   end

   // ---------------- merge: dot product sum of the three lane products
   logic signed [XW-1:0] dot_sum;
   logic [W:0]           dot_s;
   logic [W-1:0]         dot2_ff;
   logic                 dot2_ovf_ff;

   assign dot_sum = (XW'(dprod[0]) + XW'(dprod[1]) + XW'(dprod[2]) + HALF) >>> F;
   assign dot_s   = sat_fn(dot_sum);

   always_ff @(posedge clock) begin
      if (adv) begin
         dot2_ff     <= dot_s[W-1:0];
         dot2_ovf_ff <= dot_s[W];
      end
   end

   // ---------------- select stage: direct results and the vector to normalize
   logic              add_any, sub_any, scl_any, crs_any;
   pay_type           p3_in, p3_ff;
   logic [2:0][W-1:0] v3_in, v3_ff;

   assign add_any = flg[0].add_ovf   || flg[1].add_ovf   || flg[2].add_ovf;
   assign sub_any = flg[0].sub_ovf   || flg[1].sub_ovf   || flg[2].sub_ovf;
   assign scl_any = flg[0].scale_ovf || flg[1].scale_ovf || flg[2].scale_ovf;
   assign crs_any = flg[0].cross_ovf || flg[1].cross_ovf || flg[2].cross_ovf;

   always_comb begin
      p3_in      = '0;
      p3_in.kind = k2_ff;
      v3_in      = a2_ff;
      case (k2_ff)
         v3o_pkg::KIND_ADD: begin
            p3_in.rvec = {add_r[2], add_r[1], add_r[0]};
            p3_in.ovf  = add_any;
         end
         v3o_pkg::KIND_SUB: begin
            p3_in.rvec = {sub_r[2], sub_r[1], sub_r[0]};
            p3_in.ovf  = sub_any;
         end
         v3o_pkg::KIND_SCALE: begin
            p3_in.rvec = {scl_r[2], scl_r[1], scl_r[0]};
            p3_in.ovf  = scl_any;
         end
         v3o_pkg::KIND_DOT: begin
            p3_in.scal = dot2_ff;
            p3_in.ovf  = dot2_ovf_ff;
         end
         v3o_pkg::KIND_CROSS: begin
            p3_in.rvec = {crs_r[2], crs_r[1], crs_r[0]};
            p3_in.ovf  = crs_any;
         end
         v3o_pkg::KIND_UCROSS: begin
            v3_in     = {crs_r[2], crs_r[1], crs_r[0]};
            p3_in.ovf = crs_any;
         end
         v3o_pkg::KIND_USUM: begin
            v3_in     = {add_r[2], add_r[1], add_r[0]};
            p3_in.ovf = add_any;
         end
         default: begin
            // length and normalize work on A; undefined kinds end up all zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_ff <= p3_in;
         v3_ff <= v3_in;
      end
   end

   // ---------------- square stage: squares, magnitudes, signs
   pay_type               p4_in, p4_ff;
   logic signed [2*W-1:0] sq_in [3];
   logic signed [2*W-1:0] sq_ff [3];

   always_comb begin
      p4_in = p3_ff;
      for (int i = 0; i < 3; i++) begin
         p4_in.neg[i] = v3_ff[i][W-1];
         p4_in.mag[i] = v3_ff[i][W-1] ? (W'(0) - v3_ff[i]) : v3_ff[i];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_sq
      assign sq_in[i] = $signed(v3_ff[i]) * $signed(v3_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_ff <= p4_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   // ---------------- sum of squares, below 2^(2W) for any input
   pay_type        p5_ff;
   logic [2*W-1:0] s_in, s_ff;

   assign s_in = $unsigned(sq_ff[0]) + $unsigned(sq_ff[1]) + $unsigned(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_ff <= p4_ff;
         s_ff  <= s_in;
      end
   end

   // ---------------- length, with the payload delayed alongside
   logic [W:0] len;
   pay_type    pd1_ff [W+1];

   v3o_sqrt #(.W(W)) u_sqrt (
      .clock  (clock),
      .en     (adv),
      .sum_sq (s_ff),
      .len    (len)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         pd1_ff[0] <= p5_ff;
         for (int i = 1; i <= W; i++) begin
            pd1_ff[i] <= pd1_ff[i-1];
         end
      end
   end

   // ---------------- normalize: one divider per component
   pay_type      pd2_in;
   pay_type      pd2_ff [F+2];
   logic [F+1:0] quo [3];

   for (genvar i = 0; i < 3; i++) begin : g_div
      v3o_div #(.W(W), .F(F)) u_div (
         .clock (clock),
         .en    (adv),
         .mag   (pd1_ff[W].mag[i]),
         .den   (len),
         .quo   (quo[i])
      );
   end

   always_comb begin
      pd2_in     = pd1_ff[W];
      pd2_in.len = len;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pd2_ff[0] <= pd2_in;
         for (int i = 1; i <= F+1; i++) begin
            pd2_ff[i] <= pd2_ff[i-1];
         end
      end
   end

   // ---------------- output stage: pick the result by kind
   pay_type              pf;
   logic [W:0]           len_s;
   logic signed [XW-1:0] qx [3];
   logic [W:0]           q_s [3];
   logic [2:0][W-1:0]    rvec_in;
   logic [W-1:0]         scal_in;
   logic                 zl_in, ovf_in;
   logic [2:0][W-1:0]    rvec_ff;
   logic [W-1:0]         scal_ff;
   logic                 zl_ff, ovf_ff;

   assign pf    = pd2_ff[F+1];
   assign len_s = sat_fn(XW'({1'b0, pf.len}));

   for (genvar i = 0; i < 3; i++) begin : g_sign
      assign qx[i]  = pf.neg[i] ? (XW'(0) - XW'(quo[i])) : XW'(quo[i]);
      assign q_s[i] = sat_fn(qx[i]);
   end

   always_comb begin
      rvec_in = '0;
      scal_in = '0;
      zl_in   = 1'b0;
      ovf_in  = 1'b0;
      case (pf.kind)
         v3o_pkg::KIND_ADD, v3o_pkg::KIND_SUB, v3o_pkg::KIND_SCALE,
         v3o_pkg::KIND_DOT, v3o_pkg::KIND_CROSS: begin
            rvec_in = pf.rvec;
            scal_in = pf.scal;
            ovf_in  = pf.ovf;
         end
         v3o_pkg::KIND_LENGTH: begin
            scal_in = len_s[W-1:0];
            ovf_in  = len_s[W];
         end
         v3o_pkg::KIND_NORM, v3o_pkg::KIND_UCROSS, v3o_pkg::KIND_USUM: begin
            if (pf.len == '0) begin
               // zero-length vector: zero result, flag it
               zl_in  = 1'b1;
               ovf_in = pf.ovf;
            end else begin
               rvec_in = {q_s[2][W-1:0], q_s[1][W-1:0], q_s[0][W-1:0]};
               ovf_in  = pf.ovf || q_s[0][W] || q_s[1][W] || q_s[2][W];
            end
         end
         default: begin
            // undefined kinds answer with zeros and no flags
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rvec_ff <= rvec_in;
         scal_ff <= scal_in;
         zl_ff   <= zl_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_ch.valid       = vld_ff[NST-1];
   assign rsp_ch.rx          = rvec_ff[0];
   assign rsp_ch.ry          = rvec_ff[1];
   assign rsp_ch.rz          = rvec_ff[2];
   assign rsp_ch.scalar_out  = scal_ff;
   assign rsp_ch.zero_length = zl_ff;
   assign rsp_ch.overflow    = ovf_ff;

   // ---------------- checks
   // accepted request enters the first stage
   `V3O_ASSERT_NEXT(a_accept_enters, req_ch.valid && req_ch.ready, vld_ff[0])
   // a stalled pipeline keeps every stage's valid bit
   `V3O_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_ff))
   // zero-length results carry a zero vector and no scalar
   `V3O_ASSERT_IMPL(a_zero_len_clean, rsp_ch.valid && rsp_ch.zero_length,
      rsp_ch.rx == '0 && rsp_ch.ry == '0 && rsp_ch.rz == '0 && rsp_ch.scalar_out == '0)
   // scalar and vector results never appear together
   `V3O_ASSERT_IMPL(a_scalar_or_vector, rsp_ch.valid && rsp_ch.scalar_out != '0,
      rsp_ch.rx == '0 && rsp_ch.ry == '0 && rsp_ch.rz == '0)
endmodule
